@@ rtl/core/lcdns_pkg.sv @@
// Shared types, codes and constants of the character display nibble sequencer.
`timescale 1ns / 1ps

package lcdns_pkg;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_CMD    = 3'd0,
    OP_CHAR   = 3'd1,
    OP_CURSOR = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_HOME   = 3'd4,
    OP_INIT   = 3'd5
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SETTLE_BYTE  = 2'd0,
    REG_SETTLE_CLEAR = 2'd1,
    REG_POWER_UP     = 2'd2
  } cfg_reg_t;

  // How the back end expands a queued request.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_INIT  = 2'd2
  } kind_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       rs;
  } req_t;

  localparam int unsigned WAIT_W = 16;
  localparam int unsigned STEP_W = 4;

  localparam logic [WAIT_W-1:0] WAIT_MAX          = 16'hFFFF;
  localparam logic [WAIT_W-1:0] INIT_WAIT_FIRST   = 16'd10000;
  localparam logic [WAIT_W-1:0] INIT_WAIT_SHORT   = 16'd5000;
  localparam logic [WAIT_W-1:0] RST_SETTLE_BYTE   = 16'd50;
  localparam logic [WAIT_W-1:0] RST_SETTLE_CLEAR  = 16'd10000;
  localparam logic [WAIT_W-1:0] RST_POWER_UP      = 16'd20000;

  localparam logic [STEP_W-1:0] BYTE_LAST_STEP    = 4'd1;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP    = 4'd11;
  localparam logic [STEP_W-1:0] INIT_FIRST_BYTE   = 4'd4;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [4:0] MAX_COLUMN   = 5'd20;
  localparam logic [2:0] MAX_ROW      = 3'd4;

  // Display memory offset of each row.
  function automatic logic [7:0] row_offset(input logic [1:0] idx);
    logic [7:0] off;
    case (idx)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  // Command bytes sent after the nibble-mode wake-up pulses.
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h06;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/lcdns_front.sv @@
// Front end: takes requests and classifies them into queue entries.
`timescale 1ns / 1ps

module lcdns_front (
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [7:0]        in_byte_value,
  input  logic [4:0]        in_column,
  input  logic [2:0]        in_row,
  input  logic              q_full,
  output logic              q_push,
  output lcdns_pkg::req_t   q_req
);
  import lcdns_pkg::*;

  logic       keep;
  logic       pos_ok;
  logic [1:0] row_idx;
  logic [7:0] cursor_byte;

  // A request is taken whenever the queue has room.
  assign busy = q_full;

  // Cursor position check and set-address command.
  assign pos_ok = (in_row >= 3'd1) && (in_row <= MAX_ROW) &&
                  (in_column >= 5'd1) && (in_column <= MAX_COLUMN);
  assign row_idx = in_row[1:0] - 2'd1;
  assign cursor_byte = CMD_SET_DDRAM + row_offset(row_idx) + {3'b000, in_column} - 8'd1;

  // Classify the operation; bad positions and unused codes are dropped.
  always_comb begin
    keep       = 1'b1;
    q_req.kind = KIND_BYTE;
    q_req.data = in_byte_value;
    q_req.rs   = 1'b0;
    unique case (op_t'(in_operation))
      OP_CMD: begin
      end
      OP_CHAR: begin
        q_req.rs = 1'b1;
      end
      OP_CURSOR: begin
        q_req.data = cursor_byte;
        keep       = pos_ok;
      end
      OP_CLEAR: begin
        q_req.kind = KIND_CLEAR;
        q_req.data = CMD_CLEAR;
      end
      OP_HOME: begin
        q_req.kind = KIND_CLEAR;
        q_req.data = CMD_HOME;
      end
      OP_INIT: begin
        q_req.kind = KIND_INIT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = start && !q_full && keep;

endmodule

@@ rtl/core/lcdns_queue.sv @@
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module lcdns_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcdns_pkg::req_t push_req,
  input  logic            pop,
  output lcdns_pkg::req_t pop_req,
  output logic            empty,
  output logic            full
);
  import lcdns_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  req_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_FULL);
  assign pop_req = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count above depth");
`endif

endmodule

@@ rtl/core/lcdns_back.sv @@
// Back end: expands queued requests into one bus transfer beat per cycle.
`timescale 1ns / 1ps

module lcdns_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lcdns_pkg::req_t                q_req,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [lcdns_pkg::WAIT_W-1:0]   settle_byte,
  input  logic [lcdns_pkg::WAIT_W-1:0]   settle_clear,
  input  logic [lcdns_pkg::WAIT_W-1:0]   power_up,
  output logic                           out_valid,
  output logic [3:0]                     out_nibble,
  output logic                           out_register_select,
  output logic [lcdns_pkg::WAIT_W-1:0]   out_wait_before_us,
  output logic [lcdns_pkg::WAIT_W-1:0]   out_wait_after_us,
  output logic                           out_last
);
  import lcdns_pkg::*;

  back_state_t       state_r, state_nxt;
  req_t              cur_r, cur_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              valid_r;
  logic [3:0]        nib_r;
  logic              rs_r;
  logic [WAIT_W-1:0] before_r;
  logic [WAIT_W-1:0] after_r;
  logic              last_r;

  logic [WAIT_W:0]   clr_sum;
  logic [WAIT_W-1:0] clr_wait;
  logic [1:0]        init_idx;
  logic [7:0]        xfer_byte;
  logic [3:0]        xfer_nib;
  logic [WAIT_W-1:0] xfer_before;
  logic [WAIT_W-1:0] xfer_after;
  logic              xfer_last;

  // Settle time after clear or home, saturated.
  assign clr_sum  = {1'b0, settle_byte} + {1'b0, settle_clear};
  assign clr_wait = clr_sum[WAIT_W] ? WAIT_MAX : clr_sum[WAIT_W-1:0];

  // Init steps from four on send two nibbles of a fixed command each.
  assign init_idx = step_r[2:1] - 2'd2;

  // Transfer of the current step.
  always_comb begin
    xfer_byte   = cur_r.data;
    xfer_before = '0;
    xfer_last   = 1'b0;
    if (cur_r.kind == KIND_INIT) begin
      xfer_byte = init_byte(init_idx);
      xfer_last = (step_r == INIT_LAST_STEP);
    end else begin
      xfer_last = (step_r == BYTE_LAST_STEP);
    end
    xfer_nib = step_r[0] ? xfer_byte[3:0] : xfer_byte[7:4];
    if (!step_r[0]) begin
      xfer_after = '0;
    end else if (cur_r.kind == KIND_CLEAR || xfer_last) begin
      xfer_after = (cur_r.kind == KIND_BYTE) ? settle_byte : clr_wait;
    end else begin
      xfer_after = settle_byte;
    end
    // The wake-up pulses before nibble mode is set.
    if (cur_r.kind == KIND_INIT && step_r < INIT_FIRST_BYTE) begin
      unique case (step_r[1:0])
        2'd0: begin
          xfer_nib    = 4'h3;
          xfer_before = power_up;
          xfer_after  = INIT_WAIT_FIRST;
        end
        2'd1: begin
          xfer_nib   = 4'h3;
          xfer_after = INIT_WAIT_SHORT;
        end
        2'd2: begin
          xfer_nib   = 4'h3;
          xfer_after = '0;
        end
        default: begin
          xfer_nib   = 4'h2;
          xfer_after = INIT_WAIT_SHORT;
        end
      endcase
    end
  end

  // Sequencer: load a request, walk its steps, chain straight into the next.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_req;
          step_nxt  = '0;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (!xfer_last) begin
          step_nxt = step_r + 1'b1;
        end else if (!q_empty) begin
          q_pop    = 1'b1;
          cur_nxt  = q_req;
          step_nxt = '0;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      valid_r <= (state_r == BK_RUN);
    end
  end

  // Request and output beat registers.
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    nib_r    <= xfer_nib;
    rs_r     <= cur_r.rs;
    before_r <= xfer_before;
    after_r  <= xfer_after;
    last_r   <= xfer_last;
  end

  assign out_valid           = valid_r;
  assign out_nibble          = nib_r;
  assign out_register_select = rs_r;
  assign out_wait_before_us  = before_r;
  assign out_wait_after_us   = after_r;
  assign out_last            = last_r;

`ifndef SYNTHESIS
  a_run_beats: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_RUN |=> out_valid) else $error("running step gave no beat");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_IDLE |=> !out_valid) else $error("beat while idle");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= INIT_LAST_STEP) else $error("step past end of init");
  a_before_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_before_us != '0 |-> out_nibble == 4'h3 && !out_last)
    else $error("wait before on a transfer other than the first init pulse");
`endif

endmodule

@@ rtl/core/char_lcd_nibble_sequencer_unit.sv @@
// Top level of the character display nibble sequencer with its timing registers.
`timescale 1ns / 1ps

// Each request becomes a run of 4-bit display bus transfers, one beat per clock
// cycle on out_valid: two beats for a command, character, cursor move, clear or
// home, twelve for init, none for a bad cursor position or an unused code. When
// the back end is idle, a taken request is queued, loaded by the back end and its
// first beat registered; queued requests' beats follow without gaps. The back-end
// sequencer, one transfer per cycle, sets the sustained rate; requests wait in a
// QUEUE_DEPTH-entry queue and busy is high only while that queue is full. Beats
// cannot be stalled: the receiver must take one every cycle out_valid is high.
// Write the timing registers only while no request is in flight.
module char_lcd_nibble_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_byte_value,
  input  logic [4:0]  in_column,
  input  logic [2:0]  in_row,
  output logic        out_valid,
  output logic [3:0]  out_nibble,
  output logic        out_register_select,
  output logic [15:0] out_wait_before_us,
  output logic [15:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdns_pkg::*;

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  req_t              push_req;
  req_t              pop_req;
  logic [WAIT_W-1:0] settle_byte_r, settle_byte_nxt;
  logic [WAIT_W-1:0] settle_clear_r, settle_clear_nxt;
  logic [WAIT_W-1:0] power_up_r, power_up_nxt;

  // Timing register writes; an unknown index is ignored.
  always_comb begin
    settle_byte_nxt  = settle_byte_r;
    settle_clear_nxt = settle_clear_r;
    power_up_nxt     = power_up_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETTLE_BYTE:  settle_byte_nxt  = cfg_data;
        REG_SETTLE_CLEAR: settle_clear_nxt = cfg_data;
        REG_POWER_UP:     power_up_nxt     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_byte_r  <= RST_SETTLE_BYTE;
      settle_clear_r <= RST_SETTLE_CLEAR;
      power_up_r     <= RST_POWER_UP;
    end else begin
      settle_byte_r  <= settle_byte_nxt;
      settle_clear_r <= settle_clear_nxt;
      power_up_r     <= power_up_nxt;
    end
  end

  lcdns_front u_front (
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_byte_value(in_byte_value),
    .in_column    (in_column),
    .in_row       (in_row),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_req        (push_req)
  );

  lcdns_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_req(push_req),
    .pop     (q_pop),
    .pop_req (pop_req),
    .empty   (q_empty),
    .full    (q_full)
  );

  lcdns_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_req              (pop_req),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .settle_byte        (settle_byte_r),
    .settle_clear       (settle_clear_r),
    .power_up           (power_up_r),
    .out_valid          (out_valid),
    .out_nibble         (out_nibble),
    .out_register_select(out_register_select),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule

@@ tb/sv/tb_char_lcd_nibble_sequencer_unit.sv @@
// Self-checking testbench for the character display nibble sequencer unit.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer_unit;
  import lcdns_pkg::*;

  // Codes and constants of the display protocol, as the predictor sees them.
  localparam logic [2:0]  OP_SPARE_6      = 3'd6;
  localparam logic [2:0]  OP_SPARE_7      = 3'd7;
  localparam logic [1:0]  REG_UNMAPPED    = 2'd3;
  localparam logic [15:0] WAIT_CEIL       = 16'hFFFF;
  localparam logic [15:0] WAKE_WAIT_LONG  = 16'd10000;
  localparam logic [15:0] WAKE_WAIT_SHORT = 16'd5000;
  localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0]  FOUR_BIT_NIBBLE = 4'h2;
  localparam logic [7:0]  DISP_WIPE_CMD   = 8'h01;
  localparam logic [7:0]  LCD_HOME        = 8'h02;
  localparam logic [7:0]  LCD_SET_ADDR    = 8'h80;
  localparam logic [7:0]  LCD_FUNC_SET    = 8'h28;
  localparam logic [7:0]  LCD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0]  LCD_ENTRY_MODE  = 8'h06;
  localparam logic [4:0]  LAST_COLUMN     = 5'd20;
  localparam logic [2:0]  LAST_ROW        = 3'd4;

  localparam int DIR_ROWS        = 22;
  localparam int NUM_PHASES      = 7;
  localparam int BUSY_PER_PHASE  = 44;
  localparam int SETTLE_CYCLES   = 40;
  localparam int TIMEOUT_NS      = 5_000_000;

  // One transfer on the display bus.
  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [15:0] pre_wait;
    logic [15:0] after;
    logic        last;
  } lcd_beat_t;

  // One directed request; typed rows carry their two-beat result inline.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  value;
    logic [4:0]  col;
    logic [2:0]  row;
    logic        typed;
    logic        has_beats;
    logic [7:0]  t_byte;
    logic        t_rs;
    logic [15:0] t_after;
  } dir_row_t;

  // Timing register setting of one phase.
  typedef struct packed {
    logic [15:0] settle_byte;
    logic [15:0] settle_clear;
    logic [15:0] power_up;
    logic        pick_random;
  } timing_set_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [7:0]  in_byte_value;
  logic [4:0]  in_column;
  logic [2:0]  in_row;
  logic        out_valid;
  logic [3:0]  out_nibble;
  logic        out_register_select;
  logic [15:0] out_wait_before_us;
  logic [15:0] out_wait_after_us;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Shadow of the timing registers and the transfers still owed by the block.
  logic [15:0] cfg_settle_byte;
  logic [15:0] cfg_settle_clear;
  logic [15:0] cfg_power_up;
  lcd_beat_t   pending_beats[$];

  int error_count;
  int requests_sent;
  int silent_requests;
  int beats_checked;
  int settings_used;

  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{OP_CMD,     8'h00, 5'd0,  3'd0, 1'b1, 1'b1, 8'h00, 1'b0, 16'd50},
    '{OP_CMD,     8'hFF, 5'd31, 3'd7, 1'b1, 1'b1, 8'hFF, 1'b0, 16'd50},
    '{OP_CHAR,    8'hA5, 5'd10, 3'd2, 1'b1, 1'b1, 8'hA5, 1'b1, 16'd50},
    '{OP_CHAR,    8'h5A, 5'd21, 3'd5, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CHAR,    8'hFF, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CLEAR,   8'h00, 5'd0,  3'd0, 1'b1, 1'b1, 8'h01, 1'b0, 16'd10050},
    '{OP_HOME,    8'hFF, 5'd31, 3'd7, 1'b1, 1'b1, 8'h02, 1'b0, 16'd10050},
    '{OP_CURSOR,  8'h00, 5'd1,  3'd1, 1'b1, 1'b1, 8'h80, 1'b0, 16'd50},
    '{OP_CURSOR,  8'hFF, 5'd20, 3'd4, 1'b1, 1'b1, 8'hE7, 1'b0, 16'd50},
    '{OP_CURSOR,  8'h00, 5'd20, 3'd1, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd1,  3'd2, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd16, 3'd3, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd0,  3'd1, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd21, 3'd4, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'hFF, 5'd31, 3'd7, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd1,  3'd0, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CURSOR,  8'h00, 5'd20, 3'd5, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_INIT,    8'h00, 5'd0,  3'd0, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_SPARE_6, 8'hFF, 5'd31, 3'd7, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_SPARE_7, 8'h00, 5'd0,  3'd0, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_CMD,     8'h3C, 5'd7,  3'd3, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{OP_INIT,    8'hFF, 5'd31, 3'd7, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0}
  };

  // Phase 0 keeps the reset values; later phases rewrite every register.
  timing_set_t timing_sets [0:NUM_PHASES-1] = '{
    '{16'd50,    16'd10000, 16'd20000, 1'b0},
    '{16'd0,     16'd0,     16'd0,     1'b0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0},
    '{16'd30000, 16'd35535, 16'd1,     1'b0},
    '{16'd30000, 16'd35536, 16'hFFFE,  1'b0},
    '{16'd0,     16'd0,     16'd0,     1'b1},
    '{16'd0,     16'd0,     16'd0,     1'b1}
  };

  char_lcd_nibble_sequencer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_byte_value       (in_byte_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_nibble          (out_nibble),
    .out_register_select (out_register_select),
    .out_wait_before_us  (out_wait_before_us),
    .out_wait_after_us   (out_wait_after_us),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Wait sums are clamped at the top of the 16-bit range.
  function automatic logic [15:0] sat_wait(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16] ? WAIT_CEIL : sum[15:0];
  endfunction

  task automatic queue_transfer(input logic [3:0] nib, input logic rs,
                                input logic [15:0] pre_wait, input logic [15:0] after,
                                input logic last);
    lcd_beat_t beat;
    beat.nibble   = nib;
    beat.rs       = rs;
    beat.pre_wait = pre_wait;
    beat.after    = after;
    beat.last     = last;
    pending_beats.push_back(beat);
  endtask

  // A byte leaves as high nibble, then low nibble with the settle wait.
  task automatic queue_byte(input logic [7:0] value, input logic rs,
                            input logic [15:0] after, input logic last);
    queue_transfer(value[7:4], rs, 16'd0, 16'd0, 1'b0);
    queue_transfer(value[3:0], rs, 16'd0, after, last);
  endtask

  // Expands one accepted request into the transfers it must produce.
  task automatic predict_transfers(input logic [2:0] op, input logic [7:0] value,
                                   input logic [4:0] col, input logic [2:0] row,
                                   output int n_beats);
    logic [15:0] clear_wait;
    logic [7:0]  row_base;
    clear_wait = sat_wait(cfg_settle_byte, cfg_settle_clear);
    n_beats = 2;
    case (row)
      3'd1:    row_base = 8'h00;
      3'd2:    row_base = 8'h40;
      3'd3:    row_base = 8'h14;
      default: row_base = 8'h54;
    endcase
    case (op)
      OP_CMD:   queue_byte(value, 1'b0, cfg_settle_byte, 1'b1);
      OP_CHAR:  queue_byte(value, 1'b1, cfg_settle_byte, 1'b1);
      OP_CLEAR: queue_byte(DISP_WIPE_CMD, 1'b0, clear_wait, 1'b1);
      OP_HOME:  queue_byte(LCD_HOME, 1'b0, clear_wait, 1'b1);
      OP_CURSOR: begin
        // Off-screen positions are dropped without any bus activity.
        if (row < 3'd1 || row > LAST_ROW || col < 5'd1 || col > LAST_COLUMN) begin
          n_beats = 0;
        end else begin
          queue_byte(LCD_SET_ADDR + row_base + {3'b000, col} - 8'd1, 1'b0,
                     cfg_settle_byte, 1'b1);
        end
      end
      OP_INIT: begin
        queue_transfer(WAKE_NIBBLE, 1'b0, cfg_power_up, WAKE_WAIT_LONG, 1'b0);
        queue_transfer(WAKE_NIBBLE, 1'b0, 16'd0, WAKE_WAIT_SHORT, 1'b0);
        queue_transfer(WAKE_NIBBLE, 1'b0, 16'd0, 16'd0, 1'b0);
        queue_transfer(FOUR_BIT_NIBBLE, 1'b0, 16'd0, WAKE_WAIT_SHORT, 1'b0);
        queue_byte(LCD_FUNC_SET, 1'b0, cfg_settle_byte, 1'b0);
        queue_byte(LCD_DISPLAY_ON, 1'b0, cfg_settle_byte, 1'b0);
        queue_byte(LCD_ENTRY_MODE, 1'b0, cfg_settle_byte, 1'b0);
        queue_byte(DISP_WIPE_CMD, 1'b0, clear_wait, 1'b1);
        n_beats = 12;
      end
      default: n_beats = 0;
    endcase
  endtask

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(input logic [2:0] op, input logic [7:0] value,
                              input logic [4:0] col, input logic [2:0] row);
    start         <= 1'b1;
    in_operation  <= op;
    in_byte_value <= value;
    in_column     <= col;
    in_row        <= row;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  // Writes one timing register; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_SETTLE_BYTE:  cfg_settle_byte  = value;
      REG_SETTLE_CLEAR: cfg_settle_clear = value;
      REG_POWER_UP:     cfg_power_up     = value;
      default: ;
    endcase
  endtask

  // Waits until every owed transfer has come, then lets dropped requests clear.
  task automatic drain_transfers();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every strobed transfer is compared with the oldest owed one.
  always @(posedge clk) begin
    lcd_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer nibble %0h", out_nibble));
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (out_nibble !== want.nibble)
          report_mismatch($sformatf("nibble: expected %0h, got %0h",
                                    want.nibble, out_nibble));
        if (out_register_select !== want.rs)
          report_mismatch($sformatf("register_select: expected %0b, got %0b",
                                    want.rs, out_register_select));
        if (out_wait_before_us !== want.pre_wait)
          report_mismatch($sformatf("wait_before_us: expected %0d, got %0d",
                                    want.pre_wait, out_wait_before_us));
        if (out_wait_after_us !== want.after)
          report_mismatch($sformatf("wait_after_us: expected %0d, got %0d",
                                    want.after, out_wait_after_us));
        if (out_last !== want.last)
          report_mismatch($sformatf("last: expected %0b, got %0b",
                                    want.last, out_last));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int          i;
    int          phase;
    int          n_beats;
    int          busy_items;
    int          pick;
    logic        idle_on;
    dir_row_t    row_item;
    timing_set_t tset;
    logic [2:0]  op;
    logic [7:0]  value;
    logic [4:0]  col;
    logic [2:0]  row;

    error_count      = 0;
    requests_sent    = 0;
    silent_requests  = 0;
    beats_checked    = 0;
    settings_used    = 1;
    cfg_settle_byte  = 16'd50;
    cfg_settle_clear = 16'd10000;
    cfg_power_up     = 16'd20000;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_operation  <= OP_CMD;
    in_byte_value <= 8'h00;
    in_column     <= 5'd0;
    in_row        <= 3'd0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SETTLE_BYTE;
    cfg_data      <= 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests, back to back so the request queue fills up.
    for (i = 0; i < DIR_ROWS; i++) begin
      row_item = dir_table[i];
      send_request(row_item.op, row_item.value, row_item.col, row_item.row);
      if (row_item.typed) begin
        n_beats = row_item.has_beats ? 2 : 0;
        if (row_item.has_beats)
          queue_byte(row_item.t_byte, row_item.t_rs, row_item.t_after, 1'b1);
      end else begin
        predict_transfers(row_item.op, row_item.value, row_item.col, row_item.row,
                          n_beats);
      end
      if (n_beats == 0) silent_requests++;
    end

    // Random requests under each timing setting.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_transfers();
      if (phase != 0) begin
        tset = timing_sets[phase];
        if (tset.pick_random) begin
          tset.settle_byte  = 16'($urandom_range(0, 65535));
          tset.settle_clear = 16'($urandom_range(0, 65535));
          tset.power_up     = 16'($urandom_range(0, 65535));
        end
        // A write to the unmapped index must leave all registers alone.
        write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
        write_reg(REG_SETTLE_BYTE, tset.settle_byte);
        write_reg(REG_SETTLE_CLEAR, tset.settle_clear);
        write_reg(REG_POWER_UP, tset.power_up);
        cfg_we <= 1'b0;
        settings_used++;
      end

      busy_items = 0;
      idle_on    = 1'b1;
      while (busy_items < BUSY_PER_PHASE) begin
        // Idle bursts come and go; the final phase runs without them.
        if ($urandom_range(0, 11) == 0) idle_on = !idle_on;
        if (phase != NUM_PHASES - 1 && idle_on && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end

        value = 8'($urandom_range(0, 255));
        col   = 5'($urandom_range(0, 31));
        row   = 3'($urandom_range(0, 7));
        pick  = $urandom_range(0, 99);
        if (pick < 25)      op = OP_CMD;
        else if (pick < 50) op = OP_CHAR;
        else if (pick < 70) op = OP_CURSOR;
        else if (pick < 78) op = OP_CLEAR;
        else if (pick < 86) op = OP_HOME;
        else if (pick < 94) op = OP_INIT;
        else                op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;

        // Most cursor moves land on screen; the rest are anywhere.
        if (op == OP_CURSOR && $urandom_range(0, 4) != 0) begin
          col = 5'($urandom_range(1, 20));
          row = 3'($urandom_range(1, 4));
        end

        send_request(op, value, col, row);
        predict_transfers(op, value, col, row, n_beats);
        if (n_beats == 0) silent_requests++;
        else busy_items++;
      end
    end

    drain_transfers();

    $display("Run covered %0d requests (%0d with no transfers) under %0d timing settings.",
             requests_sent, silent_requests, settings_used);
    $display("%0d bus transfers were compared field by field.", beats_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
